// ===== hdl/cqfa_pkg.sv =====
`default_nettype none

package cqfa_pkg;

    // Default size of the coefficient matrix and of the amplitude store.
    localparam int MAX_COLORS_DEF = 32;

    // Field widths of the stream payloads.
    localparam int CFG_W       = 6;
    localparam int IDX_W       = 5;
    localparam int COEF_W      = 32;
    localparam int AMP_W       = 32;
    localparam int ACC_W       = 64;
    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 64;

    // Bit offsets inside the input tdata, lowest field first.
    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = ROW_LSB + IDX_W;
    localparam int COEF_LSB = COL_LSB + IDX_W;
    localparam int RE_LSB   = COEF_LSB + COEF_W;
    localparam int IM_LSB   = RE_LSB + AMP_W;
    localparam int BASE_LSB = IM_LSB + AMP_W;

    // Pair products, their sum and the scaled term.
    localparam int PROD_W = 2 * AMP_W;
    localparam int PSUM_W = PROD_W + 1;
    localparam int FULL_W = COEF_W + PSUM_W;
    localparam int FRAC_W = 16;
    localparam int TERM_W = FULL_W - FRAC_W + 1;
    localparam int SUM_W  = TERM_W + 1;

    // Reset value of the colour count register.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    // Request kinds carried in tuser.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_AMP  = 1'b1;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             ovf;
    } t_sat;

    // Clamp a wide signed sum to the signed 64-bit range.
    function automatic t_sat sat64(input logic [SUM_W-1:0] v);
        t_sat r;
        r.value = v[ACC_W-1:0];
        r.ovf   = 1'b0;
        if (!((&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]))) begin
            r.ovf   = 1'b1;
            r.value = v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/color_quadratic_form_accumulator_unit.sv =====
// Colour quadratic-form accumulator.
// Input stream (s_axis): tuser selects the request kind. A load request writes one
// Q16.16 coefficient at (row, col) of the coefficient memory.
// An amplitude request stores the amplitude at the next colour position k and adds
// its diagonal term and one cross term for every earlier colour to the accumulator.
// The loop over earlier colours reads the coefficient and amplitude memories once
// per cycle and feeds a five-stage multiply pipeline. The request that completes
// an event then adds base_sum in the final state, and the result sits in the
// output register (m_axis) until it is taken. While that register is still full,
// the next event's work goes on; only the completion of that next event waits for
// the register to empty.
// Configuration: i_cfg_wr_en writes the colour count per event; write it only
// while the block is idle.
// Reset (synchronous, active low) clears the accumulator, the colour position, the
// overflow flag and the output register, and sets the colour count to 32. The
// memories are not cleared and must be loaded before use.
`default_nettype none

module color_quadratic_form_accumulator_unit #(
    parameter int MAX_COLORS = cqfa_pkg::MAX_COLORS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [cqfa_pkg::CFG_W-1:0]       i_cfg_wr_data,
    // Input stream.
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // tdata: row[4:0], col[9:5], coef[41:10], amp_re[73:42], amp_im[105:74],
    // base_sum[169:106], zero fill[175:170].
    input  wire logic [cqfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: kind[0].
    input  wire logic [0:0]                       s_axis_tuser,
    // Output stream.
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: me_sum[63:0].
    output      logic [cqfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: overflow[0].
    output      logic [0:0]                       m_axis_tuser
);

    localparam int IW    = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int DEPTH = MAX_COLORS * MAX_COLORS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int ACC_W  = cqfa_pkg::ACC_W;
    localparam int AMP_W  = cqfa_pkg::AMP_W;
    localparam int COEF_W = cqfa_pkg::COEF_W;
    localparam int PROD_W = cqfa_pkg::PROD_W;
    localparam int PSUM_W = cqfa_pkg::PSUM_W;
    localparam int FULL_W = cqfa_pkg::FULL_W;
    localparam int FRAC_W = cqfa_pkg::FRAC_W;
    localparam int TERM_W = cqfa_pkg::TERM_W;
    localparam int SUM_W  = cqfa_pkg::SUM_W;
    localparam int HALF_W = PSUM_W - 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINAL
    } t_state;

    // Field extraction from the input request.
    logic                             in_kind;
    logic [cqfa_pkg::IDX_W-1:0]       in_row;
    logic [cqfa_pkg::IDX_W-1:0]       in_col;
    logic [COEF_W-1:0]                in_coef;
    logic [AMP_W-1:0]                 in_re;
    logic [AMP_W-1:0]                 in_im;
    logic [ACC_W-1:0]                 in_base;

    assign in_kind = s_axis_tuser[0];
    assign in_row  = s_axis_tdata[cqfa_pkg::ROW_LSB +: cqfa_pkg::IDX_W];
    assign in_col  = s_axis_tdata[cqfa_pkg::COL_LSB +: cqfa_pkg::IDX_W];
    assign in_coef = s_axis_tdata[cqfa_pkg::COEF_LSB +: COEF_W];
    assign in_re   = s_axis_tdata[cqfa_pkg::RE_LSB +: AMP_W];
    assign in_im   = s_axis_tdata[cqfa_pkg::IM_LSB +: AMP_W];
    assign in_base = s_axis_tdata[cqfa_pkg::BASE_LSB +: ACC_W];

    // Control registers.
    t_state                  r_state;
    logic [cqfa_pkg::CFG_W-1:0] r_colors;
    logic [IW-1:0]           r_count;
    logic [IW-1:0]           r_k;
    logic [IW-1:0]           r_step;
    logic                    r_last;
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                    r_d1, r_d2, r_d3, r_d4;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_flag;
    logic                    r_out_valid;
    logic [ACC_W-1:0]        r_out_sum;
    logic                    r_out_ovf;

    // Payload registers.
    logic [AMP_W-1:0]        r_re;
    logic [AMP_W-1:0]        r_im;
    logic [ACC_W-1:0]        r_base;
    logic [COEF_W-1:0]       r_coef_q;
    logic [2*AMP_W-1:0]      r_amp_q;
    logic [PROD_W-1:0]       r_pre;
    logic [PROD_W-1:0]       r_pim;
    logic [COEF_W-1:0]       r_c2;
    logic [PSUM_W-1:0]       r_s;
    logic [COEF_W-1:0]       r_c3;
    logic signed [COEF_W+HALF_W-1:0] r_plo;
    logic signed [COEF_W+HALF_W-1:0] r_phi;
    logic [TERM_W-1:0]       r_term;

    // Memories.
    logic [COEF_W-1:0]       coef_mem [DEPTH];
    logic [2*AMP_W-1:0]      amp_mem  [MAX_COLORS];

    logic                    in_fire;
    logic                    load_fire;
    logic                    amp_fire;
    logic                    load_ok;
    logic [AW-1:0]           wr_addr;
    logic [IW-1:0]           rd_j;
    logic [AW-1:0]           rd_addr;
    logic [31:0]             n_eff;
    logic                    n_last;
    logic                    out_free;
    logic                    pipe_busy;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_fire     = in_fire && (in_kind == cqfa_pkg::KIND_LOAD);
    assign amp_fire      = in_fire && (in_kind == cqfa_pkg::KIND_AMP);

    // Coefficient writes outside the matrix are dropped.
    assign load_ok = (32'(in_row) < 32'(MAX_COLORS)) && (32'(in_col) < 32'(MAX_COLORS));
    assign wr_addr = AW'(IW'(in_row)) * AW'(MAX_COLORS) + AW'(IW'(in_col));

    // The first step of an amplitude is its diagonal term, then earlier colours follow.
    assign rd_j    = (r_step == '0) ? r_k : IW'(r_step - IW'(1));
    assign rd_addr = AW'(rd_j) * AW'(MAX_COLORS) + AW'(r_k);

    // Effective colour count: zero counts as one, large values are clipped.
    always_comb begin
        n_eff = 32'(r_colors);
        if (n_eff == 32'd0) begin
            n_eff = 32'd1;
        end
        if (n_eff > 32'(MAX_COLORS)) begin
            n_eff = 32'(MAX_COLORS);
        end
    end
    assign n_last = (32'(r_count) + 32'd1) >= n_eff;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign pipe_busy = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;

    // Coefficient memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (load_fire && load_ok) begin
            coef_mem[wr_addr] <= in_coef;
        end
        r_coef_q <= coef_mem[rd_addr];
    end

    // Amplitude memory: written on acceptance, read for the cross terms.
    always_ff @(posedge i_clk) begin
        if (amp_fire) begin
            amp_mem[r_count] <= {in_im, in_re};
        end
        r_amp_q <= amp_mem[rd_j];
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (amp_fire) begin
            r_re   <= in_re;
            r_im   <= in_im;
            r_base <= in_base;
        end
    end

    // Stage two: pair products; the diagonal step pairs the amplitude with itself.
    logic [AMP_W-1:0] mul_re;
    logic [AMP_W-1:0] mul_im;
    assign mul_re = r_d1 ? r_re : r_amp_q[AMP_W-1:0];
    assign mul_im = r_d1 ? r_im : r_amp_q[2*AMP_W-1:AMP_W];

    always_ff @(posedge i_clk) begin
        r_pre <= PROD_W'($signed(mul_re) * $signed(r_re));
        r_pim <= PROD_W'($signed(mul_im) * $signed(r_im));
        r_c2  <= r_coef_q;
    end

    // Stage three: exact sum of the two products.
    always_ff @(posedge i_clk) begin
        r_s  <= {r_pre[PROD_W-1], r_pre} + {r_pim[PROD_W-1], r_pim};
        r_c3 <= r_c2;
    end

    // Stage four: coefficient times the sum, split into low and high halves.
    logic signed [HALF_W-1:0] s_lo_ext;
    logic signed [HALF_W-1:0] s_hi;
    assign s_lo_ext = $signed({1'b0, r_s[31:0]});
    assign s_hi     = $signed(r_s[PSUM_W-1:32]);

    always_ff @(posedge i_clk) begin
        r_plo <= $signed(r_c3) * s_lo_ext;
        r_phi <= $signed(r_c3) * s_hi;
    end

    // Stage five: recombine, shift right by the fraction and double cross terms.
    logic [FULL_W-1:0] full_prod;
    assign full_prod = {r_phi[FULL_W-33:0], 32'b0}
                     + {{(FULL_W-COEF_W-HALF_W){r_plo[COEF_W+HALF_W-1]}}, r_plo};

    always_ff @(posedge i_clk) begin
        if (r_d4) begin
            r_term <= {full_prod[FULL_W-1], full_prod[FULL_W-1:FRAC_W]};
        end else begin
            r_term <= {full_prod[FULL_W-1:FRAC_W], 1'b0};
        end
    end

    // Saturating accumulation and the final addition of base_sum.
    cqfa_pkg::t_sat n_acc;
    cqfa_pkg::t_sat n_total;
    assign n_acc   = cqfa_pkg::sat64({{(SUM_W-ACC_W){r_acc[ACC_W-1]}}, r_acc}
                                     + {r_term[TERM_W-1], r_term});
    assign n_total = cqfa_pkg::sat64({{(SUM_W-ACC_W){r_acc[ACC_W-1]}}, r_acc}
                                     + {{(SUM_W-ACC_W){r_base[ACC_W-1]}}, r_base});

    // Sequencer, accumulator and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_colors    <= cqfa_pkg::CFG_RESET;
            r_count     <= '0;
            r_k         <= '0;
            r_step      <= '0;
            r_last      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_d1        <= 1'b0;
            r_d2        <= 1'b0;
            r_d3        <= 1'b0;
            r_d4        <= 1'b0;
            r_acc       <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_sum   <= '0;
            r_out_ovf   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_colors <= i_cfg_wr_data;
            end

            // Output register: loaded when an event completes, emptied when taken.
            if (r_state == S_FINAL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Step tags travel alongside the datapath.
            r_v1 <= (r_state == S_RUN);
            r_d1 <= (r_step == '0);
            r_v2 <= r_v1;
            r_d2 <= r_d1;
            r_v3 <= r_v2;
            r_d3 <= r_d2;
            r_v4 <= r_v3;
            r_d4 <= r_d3;
            r_v5 <= r_v4;

            if (r_v5) begin
                r_acc  <= n_acc.value;
                r_flag <= r_flag || n_acc.ovf;
            end

            case (r_state)
                S_IDLE: begin
                    if (amp_fire) begin
                        r_k     <= r_count;
                        r_step  <= '0;
                        r_last  <= n_last;
                        r_count <= n_last ? '0 : IW'(r_count + IW'(1));
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step == r_k) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= IW'(r_step + IW'(1));
                    end
                end
                S_DRAIN: begin
                    if (!pipe_busy) begin
                        r_state <= r_last ? S_FINAL : S_IDLE;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_out_sum   <= n_total.value;
                        r_out_ovf   <= r_flag || n_total.ovf;
                        r_acc       <= '0;
                        r_flag      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_sum;
    assign m_axis_tuser[0] = r_out_ovf;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Predicts the saturated event sums of the colour accumulator and checks each
// result against the oldest outstanding prediction.
class me_sum_scoreboard;
    logic signed [31:0] coef_mem   [32][32];
    logic signed [31:0] amp_re_mem [32];
    logic signed [31:0] amp_im_mem [32];
    logic signed [63:0] acc;
    logic               sat;
    int unsigned        colour_pos;
    logic [5:0]         colours;
    logic [63:0]        expected_sums [$];
    logic               expected_ovf  [$];
    int                 errors;
    int                 results_seen;
    int                 overflow_events;

    function new();
        acc             = '0;
        sat             = 1'b0;
        colour_pos      = 0;
        colours         = cqfa_pkg::CFG_RESET;
        errors          = 0;
        results_seen    = 0;
        overflow_events = 0;
    endfunction

    function void set_colours(input logic [5:0] v);
        colours = v;
    endfunction

    function int pending();
        return expected_sums.size();
    endfunction

    // Exact floor(c * (p1 + p2) / 2^16); the widest product needs 95 bits.
    function logic signed [127:0] scaled_product(input logic signed [31:0] c,
                                                 input logic signed [63:0] p1,
                                                 input logic signed [63:0] p2);
        logic signed [127:0] s;
        logic signed [127:0] cw;
        s  = p1;
        s  = s + p2;
        cw = c;
        return (s * cw) >>> 16;
    endfunction

    // Clamp to the signed 64-bit range and remember that it happened.
    function logic [63:0] clamp64(input logic [127:0] w);
        if ((&w[127:63]) || !(|w[127:63]))
            return w[63:0];
        sat = 1'b1;
        return w[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    function void add_clamped(input logic signed [127:0] t);
        logic signed [127:0] w;
        w   = acc;
        w   = w + t;
        acc = clamp64(w);
    endfunction

    // Applies one accepted request and queues the event sum when it completes.
    function void note_request(input logic kind,
                               input logic [cqfa_pkg::IN_TDATA_W-1:0] d);
        int unsigned        n;
        int unsigned        k;
        int unsigned        j;
        logic signed [63:0] re64;
        logic signed [63:0] im64;
        logic signed [63:0] rj;
        logic signed [63:0] ij;
        logic signed [63:0] base;
        logic signed [127:0] w;
        if (kind == cqfa_pkg::KIND_LOAD) begin
            coef_mem[d[cqfa_pkg::ROW_LSB +: cqfa_pkg::IDX_W]]
                    [d[cqfa_pkg::COL_LSB +: cqfa_pkg::IDX_W]] =
                d[cqfa_pkg::COEF_LSB +: cqfa_pkg::COEF_W];
            return;
        end
        n = colours;
        if (n < 1)
            n = 1;
        if (n > 32)
            n = 32;
        k    = colour_pos % 32;
        re64 = $signed(d[cqfa_pkg::RE_LSB +: cqfa_pkg::AMP_W]);
        im64 = $signed(d[cqfa_pkg::IM_LSB +: cqfa_pkg::AMP_W]);
        base = $signed(d[cqfa_pkg::BASE_LSB +: cqfa_pkg::ACC_W]);
        amp_re_mem[k] = re64[31:0];
        amp_im_mem[k] = im64[31:0];
        // Diagonal term first, then doubled cross terms with earlier colours.
        add_clamped(scaled_product(coef_mem[k][k], re64 * re64, im64 * im64));
        for (j = 0; j < k; j++) begin
            rj = amp_re_mem[j];
            ij = amp_im_mem[j];
            add_clamped(scaled_product(coef_mem[j][k], rj * re64, ij * im64) <<< 1);
        end
        colour_pos = k + 1;
        if (colour_pos >= n) begin
            w = acc;
            w = w + base;
            expected_sums.push_back(clamp64(w));
            expected_ovf.push_back(sat);
            acc        = '0;
            sat        = 1'b0;
            colour_pos = 0;
        end
    endfunction

    task log_mismatch(input string msg);
        errors++;
        if (errors <= 50)
            $display("MISMATCH: %s", msg);
    endtask

    task check_result(input logic [63:0] sum, input logic ovf);
        logic [63:0] want_sum;
        logic        want_ovf;
        results_seen++;
        if (expected_sums.size() == 0) begin
            log_mismatch($sformatf("event %0d arrived with none pending: sum %0d",
                                   results_seen, $signed(sum)));
            return;
        end
        want_sum = expected_sums.pop_front();
        want_ovf = expected_ovf.pop_front();
        if (want_ovf)
            overflow_events++;
        if (sum !== want_sum)
            log_mismatch($sformatf("event %0d sum %0d, predicted %0d", results_seen,
                                   $signed(sum), $signed(want_sum)));
        if (ovf !== want_ovf)
            log_mismatch($sformatf("event %0d overflow %b, predicted %b", results_seen,
                                   ovf, want_ovf));
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 120;
    localparam int RANDOM_ITEMS    = 1030;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [cqfa_pkg::CFG_W-1:0]       cfg_wr_data = '0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [cqfa_pkg::IN_TDATA_W-1:0]  s_tdata     = '0;
    logic [0:0]                       s_tuser     = '0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [cqfa_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]                       m_tuser;

    me_sum_scoreboard sb = new();

    // Stimulus bookkeeping: which coefficients exist and where the event stands.
    bit          written [32][32];
    int unsigned gen_pos        = 0;
    int unsigned gen_eff        = 32;
    bit          calm           = 1'b0;
    bit          wild           = 1'b0;
    int          items_sent     = 0;
    int          loads_sent     = 0;
    int          amps_sent      = 0;
    int          settings_used  = 0;
    int          cycle_count    = 0;

    color_quadratic_form_accumulator_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    // Clock with an 8 ns period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coefficients are mostly within four units either way, with the extremes mixed in.
    function automatic logic [31:0] rand_coef();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return MAX32;
        if (r == 1)
            return MIN32;
        if (r == 2)
            return '0;
        if (r == 3)
            return $urandom;
        return $urandom_range(0, 524288) - 32'd262144;
    endfunction

    // Tame amplitudes keep the sums in range; wild ones drive saturation.
    function automatic logic [31:0] rand_amp(input bit big);
        int r;
        if (!big)
            return $urandom_range(0, 2097152) - 32'd1048576;
        r = $urandom_range(0, 3);
        if (r == 0)
            return MAX32;
        if (r == 1)
            return MIN32;
        if (r == 2)
            return '0;
        return $urandom;
    endfunction

    function automatic logic [63:0] rand_base();
        int                 r;
        logic signed [63:0] b;
        r = $urandom_range(0, 9);
        if (r == 0)
            return MAX64;
        if (r == 1)
            return MIN64;
        b = $signed({$urandom, $urandom});
        if (r < 5)
            return b;
        return b >>> 23;
    endfunction

    function automatic logic [cqfa_pkg::IN_TDATA_W-1:0] pack_request(
            input logic [4:0]  row,
            input logic [4:0]  col,
            input logic [31:0] coef,
            input logic [31:0] re,
            input logic [31:0] im,
            input logic [63:0] base);
        logic [cqfa_pkg::IN_TDATA_W-1:0] d;
        d = '0;
        d[cqfa_pkg::ROW_LSB  +: cqfa_pkg::IDX_W]  = row;
        d[cqfa_pkg::COL_LSB  +: cqfa_pkg::IDX_W]  = col;
        d[cqfa_pkg::COEF_LSB +: cqfa_pkg::COEF_W] = coef;
        d[cqfa_pkg::RE_LSB   +: cqfa_pkg::AMP_W]  = re;
        d[cqfa_pkg::IM_LSB   +: cqfa_pkg::AMP_W]  = im;
        d[cqfa_pkg::BASE_LSB +: cqfa_pkg::ACC_W]  = base;
        return d;
    endfunction

    // Offers one request and returns once it has been taken.
    task automatic send_item(input logic kind,
                             input logic [cqfa_pkg::IN_TDATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic put_load(input logic [4:0] row, input logic [4:0] col,
                            input logic [31:0] coef);
        written[row][col] = 1'b1;
        send_item(cqfa_pkg::KIND_LOAD, pack_request(row, col, coef, $urandom, $urandom,
                                                    {$urandom, $urandom}));
        loads_sent++;
    endtask

    task automatic put_amp(input logic [31:0] re, input logic [31:0] im,
                           input logic [63:0] base);
        int unsigned k;
        int unsigned j;
        k = gen_pos % 32;
        // Every coefficient that this amplitude reads must exist beforehand.
        for (j = 0; j <= k; j++) begin
            if (!written[j][k])
                put_load(5'(j), 5'(k), rand_coef());
        end
        send_item(cqfa_pkg::KIND_AMP, pack_request(5'($urandom_range(0, 31)),
                                                   5'($urandom_range(0, 31)),
                                                   $urandom, re, im, base));
        amps_sent++;
        gen_pos = k + 1;
        if (gen_pos >= gen_eff)
            gen_pos = 0;
    endtask

    // Drains the block completely, lets the last work settle, then writes the count.
    task automatic change_colour_count(input logic [5:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (v < 1)
            gen_eff = 1;
        else if (v > 32)
            gen_eff = 32;
        else
            gen_eff = v;
        settings_used++;
    endtask

    // Requests, register writes and results are all observed at the clock edge.
    always @(posedge clk) begin
        if (rst_n && cfg_wr_en)
            sb.set_colours(cfg_wr_data);
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tuser[0], s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off once results are flowing
    // so that the output register stays full and the input backs up.
    initial begin
        bit held;
        int gap;
        held = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && sb.results_seen >= 25) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Request side: directed cases first, then random phases.
    initial begin
        int          phase;
        int          budget;
        int          sent;
        int          start;
        int          r;
        bit          cut_short;
        logic [5:0]  v;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A count of zero behaves as one: single-colour events with extreme values.
        change_colour_count(6'd0);
        put_load(5'd0, 5'd0, MAX32);
        put_amp(MIN32, MIN32, '0);
        put_load(5'd0, 5'd0, MIN32);
        put_amp(MAX32, MIN32, MIN64);
        put_load(5'd0, 5'd0, 32'h0001_0000);
        put_amp(32'd3, -32'sd4, MAX64);
        put_amp('0, '0, MIN64);
        // A tiny negative product must round down, towards minus infinity.
        put_load(5'd0, 5'd0, 32'hFFFF_FFFF);
        put_amp(32'd1, '0, '0);

        // Two colours with a cross term; the lower triangle must never be read.
        change_colour_count(6'd2);
        put_load(5'd1, 5'd0, MAX32);
        put_load(5'd0, 5'd1, 32'hFFFF_0000);
        put_load(5'd1, 5'd1, 32'h0000_8000);
        put_amp(MIN32, MAX32, rand_base());
        put_amp(MAX32, MIN32, 64'd1);
        put_amp(32'd5, -32'sd7, rand_base());
        put_amp(-32'sd3, 32'd2, MIN64);

        // Lower the count while an event is half done: the next amplitude ends it.
        change_colour_count(6'd3);
        put_amp(32'd100, -32'sd200, rand_base());
        put_amp(-32'sd300, 32'd400, rand_base());
        change_colour_count(6'd2);
        put_amp(32'd500, 32'd600, rand_base());

        // Random phases, each under its own colour count.
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (phase == 0)
                v = 6'd32;
            else if (phase == 1)
                v = 6'd63;
            else if (phase == 2)
                v = 6'd1;
            else begin
                r = $urandom_range(0, 19);
                if (r < 8)
                    v = 6'($urandom_range(2, 6));
                else if (r < 14)
                    v = 6'($urandom_range(7, 16));
                else if (r < 17)
                    v = 6'($urandom_range(17, 32));
                else if (r < 19)
                    v = 6'($urandom_range(33, 63));
                else
                    v = 6'd0;
            end
            change_colour_count(v);
            calm      = ($urandom_range(0, 3) == 0);
            budget    = $urandom_range(40, 120);
            cut_short = ($urandom_range(0, 4) == 0);
            sent      = 0;
            while (sent < budget || (!cut_short && gen_pos != 0)) begin
                if ($urandom_range(0, 7) == 0) begin
                    put_load(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                             rand_coef());
                end else begin
                    if (gen_pos == 0)
                        wild = ($urandom_range(0, 9) < 3);
                    put_amp(rand_amp(wild), rand_amp(wild), rand_base());
                end
                sent++;
            end
            phase++;
        end

        // Drain and allow for any late or spurious result.
        calm = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d coefficient loads and %0d amplitudes under %0d count settings.",
                 loads_sent, amps_sent, settings_used);
        $display("%0d event sums checked, %0d saturated; output held off for %0d cycles once.",
                 sb.results_seen, sb.overflow_events, HOLD_OFF_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
